>>> src/stes_pkg.sv
package stes_pkg;

	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int INDEX_BITS_DEF = 20;

	localparam int PHASE_W = 32;
	localparam int LEN_W = 20;
	localparam int RAMP_W = 16;
	localparam int GAIN_W = 15;
	localparam int SAMPLE_W = 16;
	localparam int IN_BYTE_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// shared unit operand and result widths
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 17;
	localparam int PROD_W = 51;
	localparam int OPB_W = 31;
	localparam int DIV_N_W = 31;
	localparam int DIV_D_W = 16;
	localparam int ALU_CNT_W = 5;

	localparam int Q_MAX = 32767;
	localparam int Q_MIN = -32768;
	localparam int ENV_ONE = 32768;
	localparam int ENV_SHIFT = 15;
	localparam int SCALE_SHIFT = 30;

	localparam logic [PHASE_W-1:0] NOISE_TAPS = 32'h8020_0003;
	localparam logic [PHASE_W-1:0] NOISE_SEED = 32'h0000_0001;

	// odd polynomial for sin(pi/2 x), q30
	localparam logic signed [MUL_A_W-1:0] PC9 = 34'sd172272;
	localparam logic signed [MUL_A_W-1:0] HORNER_PC [4] = '{
		-34'sd5026995,
		34'sd85569306,
		-34'sd693598668,
		34'sd1686629713
	};
	localparam logic signed [PROD_W-1:0] SCALE_ROUND = 51'sd536870912;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAVE_SHAPE      = 3'd0,
		REG_START_STEP      = 3'd1,
		REG_SWEEP_STEP      = 3'd2,
		REG_TONE_GAIN       = 3'd3,
		REG_NOISE_GAIN      = 3'd4,
		REG_LENGTH_SAMPLES  = 3'd5,
		REG_ATTACK_SAMPLES  = 3'd6,
		REG_RELEASE_SAMPLES = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SHAPE_SINE     = 2'd0,
		SHAPE_SQUARE   = 2'd1,
		SHAPE_TRIANGLE = 2'd2
	} wave_shape_t;

	typedef enum logic {
		ALU_MUL = 1'b0,
		ALU_DIV = 1'b1
	} alu_op_t;

	// mul: signed a times unsigned b; div: b divided by a[DIV_D_W-1:0]
	typedef struct packed {
		logic                        start;
		alu_op_t                     op;
		logic signed [MUL_A_W-1:0]   a;
		logic [OPB_W-1:0]            b;
	} alu_req_t;

	typedef struct packed {
		logic                        done;
		logic signed [PROD_W-1:0]    value;
	} alu_rsp_t;

	// divide by 2^16, truncating toward zero
	function automatic logic signed [PROD_W-1:0] trunc_q16(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] bias;
		bias = p[PROD_W-1] ? PROD_W'(65535) : '0;
		return (p + bias) >>> 16;
	endfunction

	// divide by 2^15, truncating toward zero
	function automatic logic signed [PROD_W-1:0] trunc_q15(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] bias;
		bias = p[PROD_W-1] ? PROD_W'(32767) : '0;
		return (p + bias) >>> ENV_SHIFT;
	endfunction

endpackage

>>> src/stes_alu.sv
module stes_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  stes_pkg::alu_req_t  req,
	output stes_pkg::alu_rsp_t  rsp
);

	logic                                   busy_q;
	logic                                   done_q;
	stes_pkg::alu_op_t                      op_q;
	logic [stes_pkg::ALU_CNT_W-1:0]         cnt_q;

	logic signed [stes_pkg::PROD_W-1:0]     mcand_q;
	logic signed [stes_pkg::PROD_W-1:0]     acc_q;
	logic [stes_pkg::OPB_W-1:0]             mplier_q;
	logic [stes_pkg::DIV_D_W-1:0]           rem_q;
	logic [stes_pkg::DIV_D_W-1:0]           dvsr_q;

	logic [stes_pkg::DIV_D_W:0]             trial;
	logic                                   fits;

	// restoring division, one dividend bit a cycle from the top
	assign trial = {rem_q, mplier_q[stes_pkg::OPB_W-1]};
	assign fits = trial >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= stes_pkg::ALU_MUL;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q <= req.op;
				cnt_q <= (req.op == stes_pkg::ALU_MUL) ?
					stes_pkg::ALU_CNT_W'(stes_pkg::MUL_B_W - 1) :
					stes_pkg::ALU_CNT_W'(stes_pkg::DIV_N_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q <= stes_pkg::PROD_W'(req.a);
			mplier_q <= req.b;
			acc_q <= '0;
			rem_q <= '0;
			dvsr_q <= req.a[stes_pkg::DIV_D_W-1:0];
		end else if (busy_q) begin
			if (op_q == stes_pkg::ALU_MUL) begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q <= mcand_q <<< 1;
				mplier_q <= {1'b0, mplier_q[stes_pkg::OPB_W-1:1]};
			end else begin
				rem_q <= fits ? stes_pkg::DIV_D_W'(trial - {1'b0, dvsr_q}) :
					trial[stes_pkg::DIV_D_W-1:0];
				acc_q <= {acc_q[stes_pkg::PROD_W-2:0], fits};
				mplier_q <= {mplier_q[stes_pkg::OPB_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.value = acc_q;

endmodule

>>> src/swept_tone_envelope_synth.sv
// One-voice sound effect generator. Each input item (a tick, bit 0 of tdata = restart) gives
// exactly one output item: a saturated signed 16-bit sample, tlast on the final sample of the
// sound and tuser[0] set when a sample was actually produced (idle ticks return zero with
// tuser[0] clear). A 32-bit phase accumulator drives a sine (degree-9 polynomial), square or
// triangle wave whose phase increment sweeps linearly; tone plus LFSR noise is scaled by a
// linear attack/release envelope. All multiplies and the envelope division run one bit a
// cycle on a single shared shift-add/shift-subtract unit. A sine sample takes six multiplies
// for the polynomial and one for its scaling besides the tone, noise and mix multiplies that
// every shape uses (only these for square, triangle or the unused shape), plus a division
// when the envelope is ramping; an idle tick uses none. Input is not ready until the tick is
// done, also while the previous sample waits unaccepted in the output register, which lets
// the next tick be accepted while a sample waits. The user must write registers through the
// cfg port only between ticks; the block itself does not enforce this.
module swept_tone_envelope_synth #(
	parameter int SINE_TABLE_BITS = stes_pkg::SINE_TABLE_BITS_DEF,
	parameter int INDEX_BITS = stes_pkg::INDEX_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [stes_pkg::IN_BYTE_W-1:0]      s_axis_tdata,   // [0] restart
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [stes_pkg::SAMPLE_W-1:0]       m_axis_tdata,   // [15:0] sample
	output logic                                m_axis_tlast,
	output logic [0:0]                          m_axis_tuser,   // [0] playing
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [stes_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [stes_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CMP_W = ((INDEX_BITS > stes_pkg::LEN_W) ? INDEX_BITS : stes_pkg::LEN_W) + 1;
	localparam int XPAD = 18 - SINE_TABLE_BITS;
	localparam logic [SINE_TABLE_BITS-2:0] QUARTER =
		(SINE_TABLE_BITS-1)'(1) << (SINE_TABLE_BITS - 2);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_WAVE  = 11'b000_0000_0010,
		ST_SQR   = 11'b000_0000_0100,
		ST_HORN  = 11'b000_0000_1000,
		ST_SINX  = 11'b000_0001_0000,
		ST_SCALE = 11'b000_0010_0000,
		ST_TONE  = 11'b000_0100_0000,
		ST_NOISE = 11'b000_1000_0000,
		ST_ENV   = 11'b001_0000_0000,
		ST_MIX   = 11'b010_0000_0000,
		ST_DONE  = 11'b100_0000_0000
	} seq_state_t;

	// registers
	logic [1:0]                                 wave_shape_q;
	logic [stes_pkg::PHASE_W-1:0]               start_step_q;
	logic signed [stes_pkg::PHASE_W-1:0]        sweep_step_q;
	logic [stes_pkg::GAIN_W-1:0]                tone_gain_q;
	logic [stes_pkg::GAIN_W-1:0]                noise_gain_q;
	logic [stes_pkg::LEN_W-1:0]                 length_q;
	logic [stes_pkg::RAMP_W-1:0]                attack_q;
	logic [stes_pkg::RAMP_W-1:0]                release_q;

	// voice state
	logic [stes_pkg::PHASE_W-1:0]               phase_acc_q;
	logic [stes_pkg::PHASE_W-1:0]               phase_step_q;
	logic [INDEX_BITS-1:0]                      idx_q;
	logic [stes_pkg::PHASE_W-1:0]               lfsr_q;
	logic                                       active_q;

	// sequencer
	seq_state_t                                 state_q;
	logic                                       launched_q;
	logic [1:0]                                 hstep_q;
	logic                                       item_play_q;
	logic                                       out_valid_q;

	// datapath
	logic signed [stes_pkg::MUL_A_W-1:0]        a_q;
	logic [stes_pkg::MUL_B_W-1:0]               z_q;
	logic signed [stes_pkg::SAMPLE_W-1:0]       w_q;
	logic signed [stes_pkg::SAMPLE_W-1:0]       tone_q;
	logic signed [stes_pkg::SAMPLE_W-1:0]       noise_q;
	logic [stes_pkg::RAMP_W-1:0]                env_q;
	logic signed [stes_pkg::SAMPLE_W-1:0]       sample_q;
	logic signed [stes_pkg::SAMPLE_W-1:0]       out_sample_q;
	logic                                       out_last_q;
	logic                                       out_playing_q;

	stes_pkg::alu_req_t                         alu_req;
	stes_pkg::alu_rsp_t                         alu_rsp;

	logic                                       out_free;
	logic                                       play_now;
	logic                                       calc_state;

	logic [SINE_TABLE_BITS-1:0]                 sin_k;
	logic [1:0]                                 sin_quad;
	logic [SINE_TABLE_BITS-2:0]                 sin_r;
	logic [stes_pkg::MUL_B_W-1:0]               sin_x;
	logic                                       sin_neg;

	logic [15:0]                                tri_u;
	logic signed [18:0]                         tri_u2;
	logic signed [18:0]                         tri_v;
	logic signed [stes_pkg::SAMPLE_W-1:0]       tri_w;
	logic signed [stes_pkg::SAMPLE_W-1:0]       sq_w;

	logic signed [stes_pkg::PROD_W-1:0]         p16;
	logic signed [stes_pkg::PROD_W-1:0]         p15;
	logic signed [stes_pkg::PROD_W-1:0]         scale_r;
	logic signed [stes_pkg::SAMPLE_W-1:0]       scale_mag;
	logic signed [stes_pkg::SAMPLE_W-1:0]       mix_sat;
	logic signed [stes_pkg::SAMPLE_W:0]         mix_in;

	logic [CMP_W-1:0]                           idx_w;
	logic [CMP_W-1:0]                           len_w;
	logic [CMP_W-1:0]                           rel_num;
	logic                                       att_on;
	logic                                       rel_on;
	logic                                       idx_ge_len;
	logic                                       env_div;
	logic                                       is_last;
	logic [stes_pkg::DIV_N_W-1:0]               div_num;

	logic signed [stes_pkg::PHASE_W+1:0]        step_sum;
	logic [stes_pkg::PHASE_W-1:0]               step_next;
	logic [stes_pkg::PHASE_W-1:0]               lfsr_next;

	stes_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_sample_q;
	assign m_axis_tlast = out_last_q;
	assign m_axis_tuser = out_playing_q;

	assign out_free = !out_valid_q || m_axis_tready;
	assign play_now = s_axis_tdata[0] ? (length_q != '0) : active_q;
	assign calc_state = state_q inside {ST_SQR, ST_HORN, ST_SINX, ST_SCALE, ST_TONE,
		ST_NOISE, ST_ENV, ST_MIX};

	// sine: mirrored quarter-wave position in q16
	assign sin_k = phase_acc_q[stes_pkg::PHASE_W-1 -: SINE_TABLE_BITS];
	assign sin_quad = sin_k[SINE_TABLE_BITS-1 -: 2];
	assign sin_r = sin_quad[0] ? (QUARTER - {1'b0, sin_k[SINE_TABLE_BITS-3:0]}) :
		{1'b0, sin_k[SINE_TABLE_BITS-3:0]};
	assign sin_x = {sin_r, {XPAD{1'b0}}};
	assign sin_neg = sin_quad[1];

	assign sq_w = phase_acc_q[stes_pkg::PHASE_W-1] ? -16'sd32767 : 16'sd32767;

	assign tri_u = phase_acc_q[stes_pkg::PHASE_W-1 -: 16];
	assign tri_u2 = $signed({2'b00, tri_u, 1'b0});

	always_comb begin
		if (tri_u < 16'd16384) begin
			tri_v = tri_u2;
		end else if (tri_u < 16'd49152) begin
			tri_v = 19'sd65536 - tri_u2;
		end else begin
			tri_v = tri_u2 - 19'sd131072;
		end
		tri_w = (tri_v > 19'sd32767) ? 16'sd32767 : tri_v[stes_pkg::SAMPLE_W-1:0];
	end

	assign p16 = stes_pkg::trunc_q16(alu_rsp.value);
	assign p15 = stes_pkg::trunc_q15(alu_rsp.value);
	assign scale_r = (alu_rsp.value + stes_pkg::SCALE_ROUND) >>> stes_pkg::SCALE_SHIFT;
	assign scale_mag = (scale_r > stes_pkg::Q_MAX) ? 16'sd32767 :
		scale_r[stes_pkg::SAMPLE_W-1:0];
	assign mix_in = (stes_pkg::SAMPLE_W+1)'(tone_q) + (stes_pkg::SAMPLE_W+1)'(noise_q);

	always_comb begin
		if (p15 > stes_pkg::Q_MAX) begin
			mix_sat = 16'sh7FFF;
		end else if (p15 < stes_pkg::Q_MIN) begin
			mix_sat = 16'sh8000;
		end else begin
			mix_sat = p15[stes_pkg::SAMPLE_W-1:0];
		end
	end

	// envelope decision, release overrides attack
	assign idx_w = CMP_W'(idx_q);
	assign len_w = CMP_W'(length_q);
	assign att_on = (attack_q != '0) && (idx_w < CMP_W'(attack_q));
	assign rel_on = (release_q != '0) && ((idx_w + CMP_W'(release_q)) > len_w);
	assign idx_ge_len = idx_w >= len_w;
	assign rel_num = len_w - idx_w;
	assign env_div = rel_on ? !idx_ge_len : att_on;
	assign div_num = rel_on ? {rel_num[stes_pkg::RAMP_W-1:0], {stes_pkg::ENV_SHIFT{1'b0}}} :
		{idx_w[stes_pkg::RAMP_W-1:0], {stes_pkg::ENV_SHIFT{1'b0}}};
	assign is_last = ((idx_w + CMP_W'(1)) >= len_w) || (idx_q == '1);

	// increment sweep saturates at both ends
	assign step_sum = $signed({2'b00, phase_step_q}) + (stes_pkg::PHASE_W+2)'(sweep_step_q);
	assign step_next = step_sum[stes_pkg::PHASE_W+1] ? '0 :
		(step_sum[stes_pkg::PHASE_W] ? '1 : step_sum[stes_pkg::PHASE_W-1:0]);
	assign lfsr_next = lfsr_q[0] ?
		({1'b0, lfsr_q[stes_pkg::PHASE_W-1:1]} ^ stes_pkg::NOISE_TAPS) :
		{1'b0, lfsr_q[stes_pkg::PHASE_W-1:1]};

	always_comb begin
		alu_req = '0;
		alu_req.op = stes_pkg::ALU_MUL;
		case (state_q)
			ST_SQR: begin
				alu_req.a = stes_pkg::MUL_A_W'(sin_x);
				alu_req.b = stes_pkg::OPB_W'(sin_x);
			end
			ST_HORN: begin
				alu_req.a = a_q;
				alu_req.b = stes_pkg::OPB_W'(z_q);
			end
			ST_SINX: begin
				alu_req.a = a_q;
				alu_req.b = stes_pkg::OPB_W'(sin_x);
			end
			ST_SCALE: begin
				alu_req.a = a_q;
				alu_req.b = stes_pkg::OPB_W'(stes_pkg::Q_MAX);
			end
			ST_TONE: begin
				alu_req.a = stes_pkg::MUL_A_W'(w_q);
				alu_req.b = stes_pkg::OPB_W'(tone_gain_q);
			end
			ST_NOISE: begin
				alu_req.a = stes_pkg::MUL_A_W'($signed(lfsr_q[stes_pkg::SAMPLE_W-1:0]));
				alu_req.b = stes_pkg::OPB_W'(noise_gain_q);
			end
			ST_ENV: begin
				alu_req.op = stes_pkg::ALU_DIV;
				alu_req.a = stes_pkg::MUL_A_W'(rel_on ? release_q : attack_q);
				alu_req.b = div_num;
			end
			ST_MIX: begin
				alu_req.a = stes_pkg::MUL_A_W'(mix_in);
				alu_req.b = stes_pkg::OPB_W'(env_q);
			end
			default: begin
			end
		endcase
		alu_req.start = calc_state && !launched_q && !((state_q == ST_ENV) && !env_div);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_shape_q <= '0;
			start_step_q <= '0;
			sweep_step_q <= '0;
			tone_gain_q <= '0;
			noise_gain_q <= '0;
			length_q <= '0;
			attack_q <= '0;
			release_q <= '0;
			phase_acc_q <= '0;
			phase_step_q <= '0;
			idx_q <= '0;
			lfsr_q <= stes_pkg::NOISE_SEED;
			active_q <= 1'b0;
			state_q <= ST_IDLE;
			launched_q <= 1'b0;
			hstep_q <= '0;
			item_play_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					stes_pkg::REG_WAVE_SHAPE:      wave_shape_q <= cfg_data[1:0];
					stes_pkg::REG_START_STEP:      start_step_q <= cfg_data;
					stes_pkg::REG_SWEEP_STEP:      sweep_step_q <= $signed(cfg_data);
					stes_pkg::REG_TONE_GAIN:       tone_gain_q <= cfg_data[stes_pkg::GAIN_W-1:0];
					stes_pkg::REG_NOISE_GAIN:      noise_gain_q <= cfg_data[stes_pkg::GAIN_W-1:0];
					stes_pkg::REG_LENGTH_SAMPLES:  length_q <= cfg_data[stes_pkg::LEN_W-1:0];
					stes_pkg::REG_ATTACK_SAMPLES:  attack_q <= cfg_data[stes_pkg::RAMP_W-1:0];
					stes_pkg::REG_RELEASE_SAMPLES: release_q <= cfg_data[stes_pkg::RAMP_W-1:0];
					default: begin
					end
				endcase
			end

			// a new sample loaded in the same cycle keeps the register full
			if (m_axis_tvalid && m_axis_tready && !((state_q == ST_DONE) && out_free)) begin
				out_valid_q <= 1'b0;
			end

			if (alu_req.start) begin
				launched_q <= 1'b1;
			end else if (alu_rsp.done) begin
				launched_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						if (s_axis_tdata[0]) begin
							phase_acc_q <= '0;
							phase_step_q <= start_step_q;
							idx_q <= '0;
							active_q <= (length_q != '0);
						end
						item_play_q <= play_now;
						state_q <= play_now ? ST_WAVE : ST_DONE;
					end
				end
				ST_WAVE: begin
					state_q <= (wave_shape_q == stes_pkg::SHAPE_SINE) ? ST_SQR : ST_TONE;
				end
				ST_SQR: begin
					if (alu_rsp.done) begin
						hstep_q <= '0;
						state_q <= ST_HORN;
					end
				end
				ST_HORN: begin
					if (alu_rsp.done) begin
						hstep_q <= hstep_q + 1'b1;
						if (&hstep_q) begin
							state_q <= ST_SINX;
						end
					end
				end
				ST_SINX: begin
					if (alu_rsp.done) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (alu_rsp.done) begin
						state_q <= ST_TONE;
					end
				end
				ST_TONE: begin
					if (alu_rsp.done) begin
						state_q <= ST_NOISE;
					end
				end
				ST_NOISE: begin
					if (alu_rsp.done) begin
						state_q <= ST_ENV;
					end
				end
				ST_ENV: begin
					if ((!launched_q && !env_div) || alu_rsp.done) begin
						state_q <= ST_MIX;
					end
				end
				ST_MIX: begin
					if (alu_rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
						if (item_play_q) begin
							phase_acc_q <= phase_acc_q + phase_step_q;
							phase_step_q <= step_next;
							lfsr_q <= lfsr_next;
							if (is_last) begin
								active_q <= 1'b0;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sample_q <= '0;
			end
			ST_WAVE: begin
				case (wave_shape_q)
					stes_pkg::SHAPE_SQUARE:   w_q <= sq_w;
					stes_pkg::SHAPE_TRIANGLE: w_q <= tri_w;
					default:                  w_q <= '0;
				endcase
			end
			ST_SQR: begin
				if (alu_rsp.done) begin
					z_q <= alu_rsp.value[32:16];
					a_q <= stes_pkg::PC9;
				end
			end
			ST_HORN: begin
				if (alu_rsp.done) begin
					a_q <= stes_pkg::HORNER_PC[hstep_q] + p16[stes_pkg::MUL_A_W-1:0];
				end
			end
			ST_SINX: begin
				if (alu_rsp.done) begin
					a_q <= p16[stes_pkg::PROD_W-1] ? '0 : p16[stes_pkg::MUL_A_W-1:0];
				end
			end
			ST_SCALE: begin
				if (alu_rsp.done) begin
					w_q <= sin_neg ? -scale_mag : scale_mag;
				end
			end
			ST_TONE: begin
				if (alu_rsp.done) begin
					tone_q <= p15[stes_pkg::SAMPLE_W-1:0];
				end
			end
			ST_NOISE: begin
				if (alu_rsp.done) begin
					noise_q <= p15[stes_pkg::SAMPLE_W-1:0];
				end
			end
			ST_ENV: begin
				if (!launched_q && !env_div) begin
					// past the end in release gives silence, otherwise full scale
					env_q <= rel_on ? '0 : stes_pkg::RAMP_W'(stes_pkg::ENV_ONE);
				end else if (alu_rsp.done) begin
					env_q <= alu_rsp.value[stes_pkg::RAMP_W-1:0];
				end
			end
			ST_MIX: begin
				if (alu_rsp.done) begin
					sample_q <= mix_sat;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_sample_q <= sample_q;
					out_last_q <= item_play_q && is_last;
					out_playing_q <= item_play_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> src/stes_checker.sv
module stes_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic [0:0]  m_axis_tuser
);

	// a stalled item holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
			$stable(m_axis_tuser))
		else $error("output item changed while stalled");

	// idle ticks return silence and never end a sound
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == 16'h0000) && !m_axis_tlast)
		else $error("idle item carries a sample or an end mark");

	// end mark only on a produced sample
	a_last_playing: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
		else $error("end mark without a sample");

	// input is never ready again straight after a tick is taken, so ticks are not taken back to back
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken back to back");

endmodule

bind swept_tone_envelope_synth stes_checker u_stes_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
